FILE: rtl/emrg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emrg_pkg
// Shared constants, register indexes and control types of the maze row
// generator.
// ----------------------------------------------------------------------------
package emrg_pkg;

  // field widths fixed by the interface
  localparam int COIN_W    = 64;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 8;
  localparam int ROWNUM_W  = 6;
  localparam int LABEL_W   = 13;

  // default parameter values
  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     DEFAULT_COLUMN_COUNT = CFG_W'(16);
  localparam logic [CFG_W-1:0]     DEFAULT_ROW_COUNT    = CFG_W'(16);

  // sequencer to label bank
  typedef struct packed {
    logic               restart;      // load initial labels and column flags
    logic               shift;        // rotate the bank by one column
    logic               merge;        // relabel set of cell 1 into set of cell 0
    logic               set_label;    // write new_label into cell 0
    logic               set_wall;     // mark cell 0 as bottom-walled
    logic               clear_walls;  // open all bottoms for a new row
    logic [LABEL_W-1:0] new_label;
  } emrg_bank_ctrl_t;

  // label bank to sequencer
  typedef struct packed {
    logic eq01;  // cell 0 and cell 1 share a set
    logic mate;  // another open cell shares the set of cell 0
  } emrg_bank_stat_t;

endpackage

FILE: rtl/emrg_label_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emrg_label_bank
// Rotating bank of per-column set labels with a broadcast compare. Cell 0
// always holds the column under work; every step rotates the bank by one.
// ----------------------------------------------------------------------------
module emrg_label_bank import emrg_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int NCOL_W      = $clog2(MAX_COLUMNS + 1)
) (
  input  logic            clk,
  input  emrg_bank_ctrl_t ctrl,
  input  logic [NCOL_W-1:0] restart_ncol,
  output emrg_bank_stat_t stat
);

  logic [LABEL_W-1:0]     labels     [MAX_COLUMNS];
  logic [LABEL_W-1:0]     lab_upd    [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] used;
  logic [MAX_COLUMNS-1:0] walled;
  logic [MAX_COLUMNS-1:0] walled_upd;
  logic                   mate;

  // parallel compare against cell 0 and cell 1
  always_comb begin
    mate = 1'b0;
    for (int k = 1; k < MAX_COLUMNS; k++) begin
      if (used[k] && !walled[k] && (labels[k] == labels[0])) begin
        mate = 1'b1;
      end
    end
  end

  assign stat.eq01 = (labels[0] == labels[1]);
  assign stat.mate = mate;

  // merge and cell 0 writes, applied before rotation
  always_comb begin
    for (int k = 0; k < MAX_COLUMNS; k++) begin
      if (ctrl.merge && used[k] && (labels[k] == labels[1])) begin
        lab_upd[k] = labels[0];
      end else begin
        lab_upd[k] = labels[k];
      end
    end
    if (ctrl.set_label) begin
      lab_upd[0] = ctrl.new_label;
    end
    walled_upd    = walled;
    walled_upd[0] = walled[0] | ctrl.set_wall;
  end

  // label, in-use and wall flags
  always_ff @(posedge clk) begin
    if (ctrl.restart) begin
      for (int k = 0; k < MAX_COLUMNS; k++) begin
        labels[k] <= LABEL_W'(k + 1);
        used[k]   <= (NCOL_W'(k) < restart_ncol);
      end
      walled <= '0;
    end else if (ctrl.clear_walls) begin
      walled <= '0;
    end else if (ctrl.shift) begin
      for (int k = 0; k < MAX_COLUMNS; k++) begin
        if (k == MAX_COLUMNS - 1) begin
          labels[k] <= lab_upd[0];
          used[k]   <= used[0];
          walled[k] <= walled_upd[0];
        end else begin
          labels[k] <= lab_upd[k+1];
          used[k]   <= used[k+1];
          walled[k] <= walled_upd[k+1];
        end
      end
    end
  end

endmodule

FILE: rtl/emrg_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emrg_seq
// Pass sequencer: configuration registers, coin and wall shift registers,
// fresh-label and row counters, and the output register.
// ----------------------------------------------------------------------------
module emrg_seq import emrg_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int NCOL_W      = $clog2(MAX_COLUMNS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COIN_W-1:0]     right_coins,
  input  logic [COIN_W-1:0]     down_coins,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COIN_W-1:0]     right_walls,
  output logic [COIN_W-1:0]     bottom_walls,
  output logic [ROWNUM_W-1:0]   row_number,
  output logic                  last_row,
  output emrg_bank_ctrl_t       ctrl,
  output logic [NCOL_W-1:0]     restart_ncol,
  input  emrg_bank_stat_t       stat
);

  localparam int STEP_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int NROW_W = $clog2(MAX_ROWS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RIGHT  = 3'd1;
  localparam logic [2:0] ST_BOTTOM = 3'd2;
  localparam logic [2:0] ST_LAST   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic [STEP_W-1:0]      step;
  logic [MAX_COLUMNS-1:0] rc_sh;
  logic [MAX_COLUMNS-1:0] dc_sh;
  logic [MAX_COLUMNS-1:0] rw_sh;
  logic [MAX_COLUMNS-1:0] bw_sh;
  logic [LABEL_W-1:0]     next_label;
  logic [ROW_W-1:0]       current_row;
  logic [CFG_W-1:0]       col_count;
  logic [CFG_W-1:0]       row_count;
  logic [CFG_W-1:0]       col_count_next;
  logic                   last_item;

  logic [NCOL_W-1:0]      ncol;
  logic [NROW_W-1:0]      nrow;
  logic [NCOL_W-1:0]      step_ext;
  logic [NCOL_W-1:0]      step_p1;
  logic                   pair;
  logic                   used_col;
  logic                   edge_col;
  logic                   last_step;
  logic                   last_calc;
  logic                   cfg_hit;
  logic                   in_fire;
  logic                   load_out;
  logic                   restart_any;
  logic                   wall_bit;
  logic [LABEL_W-1:0]     label_inc;

  // effective column and row counts
  always_comb begin
    if (col_count == '0) begin
      ncol = NCOL_W'(1);
    end else if (int'(col_count) > MAX_COLUMNS) begin
      ncol = NCOL_W'(MAX_COLUMNS);
    end else begin
      ncol = NCOL_W'(col_count);
    end
    if (row_count == '0) begin
      nrow = NROW_W'(1);
    end else if (int'(row_count) > MAX_ROWS) begin
      nrow = NROW_W'(MAX_ROWS);
    end else begin
      nrow = NROW_W'(row_count);
    end
  end

  // column count seen by a restart in this cycle
  always_comb begin
    if (rst) begin
      col_count_next = DEFAULT_COLUMN_COUNT;
    end else if (cfg_valid && (cfg_index == REG_COLUMN_COUNT)) begin
      col_count_next = cfg_data;
    end else begin
      col_count_next = col_count;
    end
    if (col_count_next == '0) begin
      restart_ncol = NCOL_W'(1);
    end else if (int'(col_count_next) > MAX_COLUMNS) begin
      restart_ncol = NCOL_W'(MAX_COLUMNS);
    end else begin
      restart_ncol = NCOL_W'(col_count_next);
    end
  end

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid &&
                     ((cfg_index == REG_COLUMN_COUNT) || (cfg_index == REG_ROW_COUNT));
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign load_out  = (state == ST_DONE) && (!out_valid || out_ready);

  assign step_ext  = NCOL_W'(step);
  assign step_p1   = step_ext + NCOL_W'(1);
  assign pair      = (step_p1 < ncol);
  assign used_col  = (step_ext < ncol);
  assign edge_col  = (step_p1 == ncol);
  assign last_step = (step == STEP_W'(MAX_COLUMNS - 1));
  assign last_calc = ((int'(current_row) + 1) >= int'(nrow));
  assign label_inc = next_label + LABEL_W'(1);

  assign restart_any = rst || cfg_hit || (load_out && last_item);

  // per-step control of the label bank
  always_comb begin
    ctrl           = '0;
    ctrl.restart   = restart_any;
    ctrl.new_label = label_inc;
    wall_bit       = 1'b0;
    state_next     = state;
    unique case (state)
      ST_IDLE: begin
        ctrl.clear_walls = in_fire;
        if (in_fire) begin
          state_next = ST_RIGHT;
        end
      end
      ST_RIGHT: begin
        ctrl.shift = 1'b1;
        if (pair) begin
          wall_bit   = rc_sh[0] || stat.eq01;
          ctrl.merge = !wall_bit;
        end else begin
          wall_bit = edge_col;
        end
        if (last_step) begin
          state_next = ST_BOTTOM;
        end
      end
      ST_BOTTOM: begin
        ctrl.shift = 1'b1;
        wall_bit   = used_col && (last_item || (dc_sh[0] && stat.mate));
        ctrl.set_label = wall_bit && !last_item;
        ctrl.set_wall  = wall_bit && !last_item;
        if (last_step) begin
          state_next = last_item ? ST_LAST : ST_DONE;
        end
      end
      ST_LAST: begin
        ctrl.shift = 1'b1;
        ctrl.merge = pair && !stat.eq01;
        wall_bit   = ctrl.merge ? 1'b0 : rw_sh[0];
        if (last_step) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer, counters and shift registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step        <= '0;
      col_count   <= DEFAULT_COLUMN_COUNT;
      row_count   <= DEFAULT_ROW_COUNT;
      next_label  <= LABEL_W'(restart_ncol) + LABEL_W'(1);
      current_row <= '0;
      last_item   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;

      // step counter wraps at the end of each pass
      if (in_fire || last_step) begin
        step <= '0;
      end else if (state != ST_IDLE && state != ST_DONE) begin
        step <= step + STEP_W'(1);
      end

      if (in_fire) begin
        rc_sh     <= right_coins[MAX_COLUMNS-1:0];
        dc_sh     <= down_coins[MAX_COLUMNS-1:0];
        last_item <= last_calc;
      end

      unique case (state)
        ST_RIGHT: begin
          rc_sh <= rc_sh >> 1;
          rw_sh <= {wall_bit, rw_sh[MAX_COLUMNS-1:1]};
        end
        ST_BOTTOM: begin
          dc_sh <= dc_sh >> 1;
          bw_sh <= {wall_bit, bw_sh[MAX_COLUMNS-1:1]};
          if (ctrl.set_label) begin
            next_label <= label_inc;
          end
        end
        ST_LAST: begin
          rw_sh <= {wall_bit, rw_sh[MAX_COLUMNS-1:1]};
        end
        ST_IDLE, ST_DONE: begin
        end
        default: begin
        end
      endcase

      // output register
      if (load_out) begin
        out_valid    <= 1'b1;
        right_walls  <= COIN_W'(rw_sh);
        bottom_walls <= COIN_W'(bw_sh);
        row_number   <= ROWNUM_W'(current_row);
        last_row     <= last_item;
        if (!last_item) begin
          current_row <= current_row + ROW_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // configuration writes
      if (cfg_valid && (cfg_index == REG_COLUMN_COUNT)) begin
        col_count <= cfg_data;
      end
      if (cfg_valid && (cfg_index == REG_ROW_COUNT)) begin
        row_count <= cfg_data;
      end

      // new maze after a register write or after the final row
      if (cfg_hit || (load_out && last_item)) begin
        next_label  <= LABEL_W'(restart_ncol) + LABEL_W'(1);
        current_row <= '0;
      end
    end
  end

endmodule

FILE: rtl/eller_maze_row_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eller_maze_row_generator_top
// Maze row generator using set merging, one row per input transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries the right and bottom coin bits of one row and
// produces one output transaction with that row's walls. The per-column set
// labels sit in a bank that rotates by one column per cycle, so every pass
// walks all MAX_COLUMNS columns with one parallel label compare per cycle:
// a right-wall pass and a bottom-wall pass (with fresh labels) make up each
// row, and the final row adds a closing merge pass. The input is not ready
// while a row is in progress; a finished row waits in the output register
// while the next row is accepted. A configuration write restarts the maze.
// ----------------------------------------------------------------------------
module eller_maze_row_generator_top import emrg_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COIN_W-1:0]    right_coins,
  input  logic [COIN_W-1:0]    down_coins,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COIN_W-1:0]    right_walls,
  output logic [COIN_W-1:0]    bottom_walls,
  output logic [ROWNUM_W-1:0]  row_number,
  output logic                 last_row
);

  localparam int NCOL_W = $clog2(MAX_COLUMNS + 1);

  emrg_bank_ctrl_t   ctrl;
  emrg_bank_stat_t   stat;
  logic [NCOL_W-1:0] restart_ncol;

  // pass sequencer
  emrg_seq #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .NCOL_W      (NCOL_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .right_coins  (right_coins),
    .down_coins   (down_coins),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .right_walls  (right_walls),
    .bottom_walls (bottom_walls),
    .row_number   (row_number),
    .last_row     (last_row),
    .ctrl         (ctrl),
    .restart_ncol (restart_ncol),
    .stat         (stat)
  );

  // rotating set-label bank
  emrg_label_bank #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .NCOL_W      (NCOL_W)
  ) u_bank (
    .clk          (clk),
    .ctrl         (ctrl),
    .restart_ncol (restart_ncol),
    .stat         (stat)
  );

endmodule

FILE: rtl/emrg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emrg_checker
// Port-level checks of the maze row generator, bound to the top level.
// ----------------------------------------------------------------------------
module emrg_checker import emrg_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [COIN_W-1:0]    right_walls,
  input logic [COIN_W-1:0]    bottom_walls,
  input logic                 last_row
);

  // a row in progress blocks the next input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a row is in progress");

  // a stalled output transaction holds its walls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(right_walls) && $stable(bottom_walls))
    else $error("output row changed while stalled");

  // every row has a right wall, as the rightmost column always does
  a_edge_wall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (right_walls != '0))
    else $error("row without any right wall");

  // the final row is closed below
  a_last_closed: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_row |-> bottom_walls[0])
    else $error("final row has an open bottom");

  // every set keeps a way down on a non-final row
  a_way_down: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_row |-> !(&bottom_walls))
    else $error("non-final row fully walled below");

endmodule

bind eller_maze_row_generator_top emrg_checker u_emrg_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .right_walls  (right_walls),
  .bottom_walls (bottom_walls),
  .last_row     (last_row)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Maze row generator check: directed table rows and register writes, then
// random mazes under random settings, scored against given or predicted walls.
// ----------------------------------------------------------------------------
module testbench;
  import emrg_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int          RANDOM_ITEMS  = 800;
  localparam int          QUIET_ITEMS   = 100;
  localparam int          DRAIN_CYCLES  = 3 * DEF_MAX_COLUMNS + 8;
  localparam int          MAX_PRINTS    = 50;

  // index that maps to no register, writes there must leave the maze alone
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(2);

  localparam logic [COIN_W-1:0] ALL_ONES = '1;
  localparam logic [COIN_W-1:0] TOP_BIT  = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [COIN_W-1:0]   right_w;
    logic [COIN_W-1:0]   bottom_w;
    logic [ROWNUM_W-1:0] row_num;
    logic                is_last;
  } row_walls_t;

  typedef enum logic {STEP_ROW, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t          kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]    reg_val;
    logic [COIN_W-1:0]   rc;
    logic [COIN_W-1:0]   dc;
    logic                typed;
    row_walls_t          want;
  } step_t;

  localparam row_walls_t NO_WANT = '0;

  // directed table: register writes, and rows with the walls typed in where
  // they are obvious (fresh maze, all-equal coins, closing rows)
  localparam int NUM_DIRECTED = 29;
  localparam step_t DIRECTED [NUM_DIRECTED] = '{
    // default 16 columns, 16 rows
    '{STEP_ROW, REG_COLUMN_COUNT, 7'd0, ALL_ONES, ALL_ONES, 1'b1,
      '{64'hFFFF, 64'h0, 6'd0, 1'b0}},
    '{STEP_ROW, REG_COLUMN_COUNT, 7'd0, 64'h0, 64'h0, 1'b1,
      '{64'h8000, 64'h0, 6'd1, 1'b0}},
    '{STEP_ROW, REG_COLUMN_COUNT, 7'd0, ALL_ONES, ALL_ONES, 1'b1,
      '{64'hFFFF, 64'h7FFF, 6'd2, 1'b0}},
    '{STEP_ROW, REG_COLUMN_COUNT, 7'd0, 64'h5555_5555_5555_5555,
      64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NO_WANT},
    '{STEP_ROW, REG_COLUMN_COUNT, 7'd0, 64'hFFFF_0000_0000_0000,
      64'h0000_FFFF_0000_FF00, 1'b0, NO_WANT},
    // single column, single row
    '{STEP_CFG, REG_COLUMN_COUNT, 7'd1, 64'h0, 64'h0, 1'b0, NO_WANT},
    '{STEP_CFG, REG_ROW_COUNT, 7'd1, 64'h0, 64'h0, 1'b0, NO_WANT},
    '{STEP_ROW, REG_COLUMN_COUNT, 7'd0, ALL_ONES, ALL_ONES, 1'b1,
      '{64'h1, 64'h1, 6'd0, 1'b1}},
    '{STEP_ROW, REG_COLUMN_COUNT, 7'd0, 64'h0, 64'h0, 1'b1,
      '{64'h1, 64'h1, 6'd0, 1'b1}},
    // zero counts behave as one
    '{STEP_CFG, REG_COLUMN_COUNT, 7'd0, 64'h0, 64'h0, 1'b0, NO_WANT},
    '{STEP_CFG, REG_ROW_COUNT, 7'd0, 64'h0, 64'h0, 1'b0, NO_WANT},
    '{STEP_ROW, REG_COLUMN_COUNT, 7'd0, ALL_ONES, 64'h0, 1'b1,
      '{64'h1, 64'h1, 6'd0, 1'b1}},
    // full width maze
    '{STEP_CFG, REG_COLUMN_COUNT, 7'd64, 64'h0, 64'h0, 1'b0, NO_WANT},
    '{STEP_CFG, REG_ROW_COUNT, 7'd64, 64'h0, 64'h0, 1'b0, NO_WANT},
    '{STEP_ROW, REG_COLUMN_COUNT, 7'd0, ALL_ONES, ALL_ONES, 1'b1,
      '{ALL_ONES, 64'h0, 6'd0, 1'b0}},
    '{STEP_ROW, REG_COLUMN_COUNT, 7'd0, 64'h0, 64'h0, 1'b1,
      '{TOP_BIT, 64'h0, 6'd1, 1'b0}},
    '{STEP_ROW, REG_COLUMN_COUNT, 7'd0, ALL_ONES, ALL_ONES, 1'b1,
      '{ALL_ONES, ~TOP_BIT, 6'd2, 1'b0}},
    '{STEP_ROW, REG_COLUMN_COUNT, 7'd0, 64'h0F0F_0F0F_0F0F_0F0F,
      64'h3333_3333_3333_3333, 1'b0, NO_WANT},
    '{STEP_ROW, REG_COLUMN_COUNT, 7'd0, 64'h0, ALL_ONES, 1'b0, NO_WANT},
    // counts above the maximum clamp, unused index is ignored mid-maze
    '{STEP_CFG, REG_COLUMN_COUNT, 7'd127, 64'h0, 64'h0, 1'b0, NO_WANT},
    '{STEP_CFG, REG_ROW_COUNT, 7'd2, 64'h0, 64'h0, 1'b0, NO_WANT},
    '{STEP_ROW, REG_COLUMN_COUNT, 7'd0, ALL_ONES, ALL_ONES, 1'b1,
      '{ALL_ONES, 64'h0, 6'd0, 1'b0}},
    '{STEP_CFG, REG_UNUSED, 7'h55, 64'h0, 64'h0, 1'b0, NO_WANT},
    '{STEP_ROW, REG_COLUMN_COUNT, 7'd0, 64'h0, 64'h0, 1'b1,
      '{TOP_BIT, ALL_ONES, 6'd1, 1'b1}},
    // two columns
    '{STEP_CFG, REG_COLUMN_COUNT, 7'd2, 64'h0, 64'h0, 1'b0, NO_WANT},
    '{STEP_CFG, REG_ROW_COUNT, 7'd127, 64'h0, 64'h0, 1'b0, NO_WANT},
    '{STEP_ROW, REG_COLUMN_COUNT, 7'd0, 64'h0, ALL_ONES, 1'b1,
      '{64'h2, 64'h1, 6'd0, 1'b0}},
    '{STEP_CFG, REG_ROW_COUNT, 7'd1, 64'h0, 64'h0, 1'b0, NO_WANT},
    '{STEP_ROW, REG_COLUMN_COUNT, 7'd0, 64'h0, 64'h0, 1'b1,
      '{64'h2, 64'h3, 6'd0, 1'b1}}
  };

  // dut signals
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [COIN_W-1:0]    right_coins = '0;
  logic [COIN_W-1:0]    down_coins = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COIN_W-1:0]    right_walls;
  logic [COIN_W-1:0]    bottom_walls;
  logic [ROWNUM_W-1:0]  row_number;
  logic                 last_row;

  // predictor state
  logic [LABEL_W-1:0] maze_labels [DEF_MAX_COLUMNS];
  logic [LABEL_W-1:0] fresh_label;
  int unsigned        maze_row;
  logic [CFG_W-1:0]   column_reg;
  logic [CFG_W-1:0]   row_reg;

  row_walls_t  pending_rows [$];
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          idling = 1'b1;
  int          stall_left = 0;

  eller_maze_row_generator_top uut (.*);

  // clock
  always begin
    #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned clamp_count(logic [CFG_W-1:0] v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return 32'(v);
  endfunction

  function automatic void maze_restart();
    int j;
    for (j = 0; j < DEF_MAX_COLUMNS; j++) maze_labels[j] = LABEL_W'(j + 1);
    fresh_label = LABEL_W'(clamp_count(column_reg, DEF_MAX_COLUMNS) + 1);
    maze_row = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_COLUMN_COUNT: column_reg = val;
      REG_ROW_COUNT:    row_reg = val;
      default:          return;
    endcase
    maze_restart();
  endfunction

  // pull the set of column j+1 into the set of column j
  function automatic void join_sets(int unsigned j, int unsigned ncol);
    logic [LABEL_W-1:0] from_set;
    logic [LABEL_W-1:0] into_set;
    int unsigned i;
    from_set = maze_labels[j + 1];
    into_set = maze_labels[j];
    for (i = 0; i < ncol; i++)
      if (maze_labels[i] == from_set) maze_labels[i] = into_set;
  endfunction

  // walls of the next row, advancing the label state
  function automatic row_walls_t predict_row(logic [COIN_W-1:0] rc, logic [COIN_W-1:0] dc);
    row_walls_t  r;
    int unsigned ncol;
    int unsigned nrow;
    int unsigned members;
    int unsigned walled;
    int unsigned i;
    int unsigned j;
    bit          closing;
    ncol = clamp_count(column_reg, DEF_MAX_COLUMNS);
    nrow = clamp_count(row_reg, DEF_MAX_ROWS);
    r = '0;
    closing = (maze_row + 1 >= nrow);

    // right walls, merging open neighbours
    for (j = 0; j + 1 < ncol; j++) begin
      if (rc[j] || maze_labels[j] == maze_labels[j + 1]) r.right_w[j] = 1'b1;
      else join_sets(j, ncol);
    end

    // bottom walls, keeping one open cell per set
    for (j = 0; j < ncol; j++) begin
      if (dc[j]) begin
        members = 0;
        walled = 0;
        for (i = 0; i < ncol; i++) begin
          if (maze_labels[i] == maze_labels[j]) begin
            members++;
            if (r.bottom_w[i]) walled++;
          end
        end
        if (members - walled > 1) r.bottom_w[j] = 1'b1;
      end
    end

    if (!closing) begin
      for (j = 0; j < ncol; j++) begin
        if (r.bottom_w[j]) begin
          fresh_label = fresh_label + 1'b1;
          maze_labels[j] = fresh_label;
        end
      end
    end else begin
      // closing row: floor everywhere, join every remaining pair of sets
      r.bottom_w = '0;
      for (j = 0; j < ncol; j++) r.bottom_w[j] = 1'b1;
      for (j = 0; j + 1 < ncol; j++) begin
        if (maze_labels[j] != maze_labels[j + 1]) begin
          r.right_w[j] = 1'b0;
          join_sets(j, ncol);
        end
      end
    end
    r.right_w[ncol - 1] = 1'b1;
    r.row_num = ROWNUM_W'(maze_row);
    r.is_last = closing;

    if (closing) maze_restart();
    else maze_row++;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [COIN_W-1:0] got,
                                 logic [COIN_W-1:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // output side: random stalls and scoring of each transaction
  always @(posedge clk) begin
    row_walls_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_rows.size() == 0) begin
        report_mismatch("row with none expected", right_walls, '0);
      end else begin
        want = pending_rows.pop_front();
        if (right_walls !== want.right_w)
          report_mismatch("right_walls", right_walls, want.right_w);
        if (bottom_walls !== want.bottom_w)
          report_mismatch("bottom_walls", bottom_walls, want.bottom_w);
        if (row_number !== want.row_num)
          report_mismatch("row_number", COIN_W'(row_number), COIN_W'(want.row_num));
        if (last_row !== want.is_last)
          report_mismatch("last_row", COIN_W'(last_row), COIN_W'(want.is_last));
      end
    end
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // register write, only once every row has come back
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  // one row transaction, with an optional idle burst in front
  task automatic send_row(logic [COIN_W-1:0] rc, logic [COIN_W-1:0] dc,
                          bit use_given, row_walls_t given);
    row_walls_t predicted;
    cfg_valid <= 1'b0;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    predicted = predict_row(rc, dc);
    in_valid <= 1'b1;
    right_coins <= rc;
    down_coins <= dc;
    do @(posedge clk); while (!in_ready);
    pending_rows.push_back(use_given ? given : predicted);
  endtask

  // coin word with varying density so that merges and walls both show up
  function automatic logic [COIN_W-1:0] coin_word();
    logic [COIN_W-1:0] a;
    logic [COIN_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1:    return a & b & {$urandom, $urandom};
      2, 3:    return a | b;
      4:       return ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
      default: return a;
    endcase
  endfunction

  initial begin
    int               k;
    int               sent;
    int               phase_items;
    logic [CFG_W-1:0] cols;
    logic [CFG_W-1:0] rows;

    column_reg = DEFAULT_COLUMN_COUNT;
    row_reg = DEFAULT_ROW_COUNT;
    maze_restart();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (k = 0; k < NUM_DIRECTED; k++) begin
      if (DIRECTED[k].kind == STEP_CFG)
        write_reg(DIRECTED[k].reg_idx, DIRECTED[k].reg_val);
      else
        send_row(DIRECTED[k].rc, DIRECTED[k].dc, DIRECTED[k].typed, DIRECTED[k].want);
    end

    // random mazes, each phase under new settings
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idling = (sent < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 5) != 0);
      case ($urandom_range(0, 7))
        0:       cols = CFG_W'($urandom_range(0, 1));
        1:       cols = CFG_W'($urandom_range(65, 127));
        2:       cols = CFG_W'(64);
        default: cols = CFG_W'($urandom_range(2, 64));
      endcase
      case ($urandom_range(0, 7))
        0:       rows = CFG_W'($urandom_range(0, 1));
        1:       rows = CFG_W'($urandom_range(65, 127));
        2:       rows = CFG_W'(64);
        default: rows = CFG_W'($urandom_range(2, 12));
      endcase
      if ($urandom_range(0, 1) != 0) begin
        write_reg(REG_COLUMN_COUNT, cols);
        write_reg(REG_ROW_COUNT, rows);
      end else begin
        write_reg(REG_ROW_COUNT, rows);
        write_reg(REG_COLUMN_COUNT, cols);
      end
      phase_items = clamp_count(rows, DEF_MAX_ROWS) * $urandom_range(1, 2)
                    + $urandom_range(0, 3);
      for (k = 0; k < phase_items; k++) send_row(coin_word(), coin_word(), 1'b0, NO_WANT);
      sent += phase_items;
    end

    // drain
    idling = 1'b0;
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_rows.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
